>>> src/sha_pkg.sv
// Shared types, constants and the rotate function for the SHA-256 stream hasher.
// Used by the controller, the datapath, the top level, the checker and the testbench.
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkBytes = 64;
  localparam int unsigned LenPos  = 56;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Byte source for a buffer write
  typedef enum logic [1:0] {
    WrData = 2'd0,
    WrPad  = 2'd1,
    WrZero = 2'd2,
    WrLen  = 2'd3
  } wr_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       buf_we;
    wr_sel_e    wr_sel;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       bits_add;
    logic       load_words;
    logic       round_en;
    logic [5:0] round_idx;
    logic       fold;
    logic       reinit;
  } dp_cmd_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

>>> src/sha_if.sv
// Valid/ready channel carrying one item of the SHA-256 hasher.
// Payload type is given as a parameter; no package dependency of its own.
`default_nettype none
interface sha_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/sha_datapath.sv
// SHA-256 datapath: message words, message bit count, schedule, round unit, hash.
// Depends on sha_pkg; driven by sha_ctrl commands.
`default_nettype none
module sha_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sha_pkg::dp_cmd_t cmd_i,
  input  wire logic [2:0]       rd_idx_i,
  output logic [31:0]           hash_word_o
);
  logic [63:0] bits_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [7:0]  wbyte;
  logic [31:0] w_cur, w_new, s0, s1, x15, x2;
  logic [31:0] t1, t2, big0, big1, ch, mj;

  // Select the byte to store
  always_comb begin
    unique case (cmd_i.wr_sel)
      sha_pkg::WrData: wbyte = cmd_i.wr_data;
      sha_pkg::WrPad:  wbyte = sha_pkg::PadByte;
      sha_pkg::WrZero: wbyte = 8'h00;
      sha_pkg::WrLen:  wbyte = bits_q[8*(7-cmd_i.wr_addr[2:0]) +: 8];
      default:         wbyte = 8'h00;
    endcase
  end

  // Bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else if (cmd_i.reinit) begin
      bits_q <= '0;
    end else if (cmd_i.bits_add) begin
      bits_q <= bits_q + 64'd8;
    end
  end

  // Schedule word for the current round; window slides by one each round
  assign x15   = w_q[1];
  assign x2    = w_q[14];
  assign s0    = sha_pkg::ror(x15, 7) ^ sha_pkg::ror(x15, 18) ^ (x15 >> 3);
  assign s1    = sha_pkg::ror(x2, 17) ^ sha_pkg::ror(x2, 19) ^ (x2 >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign w_cur = w_q[0];

  // Round function
  assign big1 = sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11) ^ sha_pkg::ror(v_q[4], 25);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + sha_pkg::RoundK[cmd_i.round_idx] + w_cur;
  assign big0 = sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13) ^ sha_pkg::ror(v_q[0], 22);
  assign mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + mj;

  // Schedule and working variables; block bytes land big-endian in the words
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_words) begin
      for (int k = 0; k < 8; k++) begin
        v_q[k] <= h_q[k];
      end
    end else if (cmd_i.round_en) begin
      for (int t = 0; t < 15; t++) begin
        w_q[t] <= w_q[t+1];
      end
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (cmd_i.buf_we) begin
      w_q[cmd_i.wr_addr[5:2]][8*(3-cmd_i.wr_addr[1:0]) +: 8] <= wbyte;
    end
  end

  // Chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) h_q[k] <= sha_pkg::InitHash[k];
    end else if (cmd_i.reinit) begin
      for (int k = 0; k < 8; k++) h_q[k] <= sha_pkg::InitHash[k];
    end else if (cmd_i.fold) begin
      for (int k = 0; k < 8; k++) h_q[k] <= h_q[k] + v_q[k];
    end
  end

  assign hash_word_o = h_q[rd_idx_i];
endmodule
`default_nettype wire

>>> src/sha_ctrl.sv
// SHA-256 controller: byte intake, padding sequence, round count, digest output.
// Depends on sha_pkg; commands the sha_datapath.
`default_nettype none
module sha_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire sha_pkg::in_item_t in_data_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             out_idx_o,
  output sha_pkg::dp_cmd_t       cmd_o,
  output logic [2:0]             rd_idx_o
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPad   = 7'b0000010,
    StLoad  = 7'b0000100,
    StRound = 7'b0001000,
    StFold  = 7'b0010000,
    StEmit  = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e     st_q, st_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] oidx_q, oidx_d;
  logic       fin_q, fin_d;   // compressing as part of finalize
  logic       last_q, last_d; // this compression is the final one
  logic       acc;

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StEmit);
  assign out_idx_o   = oidx_q;
  assign rd_idx_o    = oidx_q;

  // Sequence control
  always_comb begin
    st_d   = st_q;
    fill_d = fill_q;
    rnd_d  = rnd_q;
    oidx_d = oidx_q;
    fin_d  = fin_q;
    last_d = last_q;
    cmd_o  = '0;
    cmd_o.wr_sel    = sha_pkg::WrData;
    cmd_o.wr_addr   = fill_q;
    cmd_o.wr_data   = in_data_i.data_byte;
    cmd_o.round_idx = rnd_q;
    unique case (st_q)
      StIdle: begin
        if (acc) begin
          cmd_o.buf_we = 1'b1;
          if (!in_data_i.mode) begin
            cmd_o.bits_add = 1'b1;
            fill_d = fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              fin_d = 1'b0;
              st_d  = StLoad;
            end
          end else begin
            cmd_o.wr_sel = sha_pkg::WrPad;
            fin_d  = 1'b1;
            last_d = (fill_q < 6'(sha_pkg::LenPos));
            fill_d = fill_q + 6'd1;
            st_d   = (fill_q == 6'd63) ? StLoad : StPad;
          end
        end
      end
      // Write one fill or length byte a cycle
      StPad: begin
        cmd_o.buf_we = 1'b1;
        if (last_q && fill_q >= 6'(sha_pkg::LenPos)) begin
          cmd_o.wr_sel = sha_pkg::WrLen;
        end else begin
          cmd_o.wr_sel = sha_pkg::WrZero;
        end
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) st_d = StLoad;
      end
      StLoad: begin
        cmd_o.load_words = 1'b1;
        rnd_d = '0;
        st_d  = StRound;
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) st_d = StFold;
      end
      StFold: begin
        cmd_o.fold = 1'b1;
        if (!fin_q) begin
          st_d = StIdle;
        end else if (!last_q) begin
          last_d = 1'b1;
          st_d   = StPad;
        end else begin
          oidx_d = '0;
          st_d   = StEmit;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) st_d = StDone;
        end
      end
      StDone: begin
        cmd_o.reinit = 1'b1;
        fill_d = '0;
        fin_d  = 1'b0;
        st_d   = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      fill_q <= '0;
      rnd_q  <= '0;
      oidx_q <= '0;
      fin_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      fill_q <= fill_d;
      rnd_q  <= rnd_d;
      oidx_q <= oidx_d;
      fin_q  <= fin_d;
      last_q <= last_d;
    end
  end
endmodule
`default_nettype wire

>>> src/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on sha_pkg, sha_if, sha_ctrl and sha_datapath.
//
// Input channel: one item per message byte (mode 0) or a finalize item
// (mode 1). Output channel: eight digest words, index 0 first, last_word
// set on the eighth.
// Throughput: one absorb byte per cycle, except that the 64th byte of a
// block starts a compression (load, 64 rounds on the single round unit,
// fold) before the next byte is taken.
// A finalize item writes the pad byte, then fills the rest of the block one
// byte a cycle, compresses, and repeats once if the length did not fit,
// before the first digest word is offered.
// Words leave one per cycle while out ready is high; a stall holds the
// current word. After the last word the done state reloads the initial hash.
// Reset (asynchronous, active low) loads the initial hash and clears the
// byte and bit counts; the block then takes input at once.
`default_nettype none
module sha256_stream_hasher_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha_if.sink       in_if,
  sha_if.source     out_if
);
  sha_pkg::dp_cmd_t cmd;
  logic [2:0]       rd_idx;
  logic [2:0]       out_idx;
  logic [31:0]      hash_word;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_data_i   (in_if.data),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_idx_o   (out_idx),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx)
  );

  sha_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_idx_i    (rd_idx),
    .hash_word_o (hash_word)
  );

  assign out_if.data.digest_word = hash_word;
  assign out_if.data.word_index  = out_idx;
  assign out_if.data.last_word   = (out_idx == 3'd7);
endmodule
`default_nettype wire

>>> src/sha_checker.sv
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha_pkg through the channel payload types.
`default_nettype none
module sha_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire sha_pkg::out_item_t out_data
);
  // No input is taken while digest words are pending
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken during digest output");

  // Word index advances by one after each delivered word that is not last
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest word index skipped");

  // last_word marks index 7 only
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word mismatch");

  // A stalled word holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled digest word changed");
endmodule

bind sha256_stream_hasher_top sha_checker u_sha_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
`default_nettype wire

>>> tb/sha256_stream_hasher_top_tb.sv
// Testbench for the SHA-256 stream hasher: drives byte and finalize items,
// predicts each digest with its own SHA-256 model and checks every word.
// Depends on sha_pkg, sha_if and sha256_stream_hasher_top.
`timescale 1ns / 100ps
`default_nettype none
module sha256_stream_hasher_top_tb;

  localparam logic ModeAbsorb   = 1'b0;
  localparam logic ModeFinalize = 1'b1;

  logic clk_i;
  logic rst_ni;

  sha_if #(.item_t(sha_pkg::in_item_t))  in_if ();
  sha_if #(.item_t(sha_pkg::out_item_t)) out_if ();

  sha256_stream_hasher_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  byte_count;
  logic [63:0] bit_count;

  sha_pkg::in_item_t  send_queue [$];
  sha_pkg::out_item_t digest_queue [$];
  int        errors;
  int        words_seen;
  int        digests_sent;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_off;

  // Run one compression over msg_block
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = sha_pkg::ror(w[t-15], 7) ^ sha_pkg::ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = sha_pkg::ror(w[t-2], 17) ^ sha_pkg::ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
           + ((e & f) ^ (~e & g)) + sha_pkg::RoundK[t] + w[t];
      t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
           + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void reload_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::InitHash[i];
    byte_count = '0;
    bit_count  = '0;
  endfunction

  // Advance the predictor by one accepted item
  function automatic void predict_item(sha_pkg::in_item_t it);
    int i;
    sha_pkg::out_item_t o;
    if (it.mode == ModeAbsorb) begin
      msg_block[byte_count] = it.data_byte;
      bit_count += 64'd8;
      byte_count += 6'd1;
      if (byte_count == 0) compress_block();
      return;
    end
    i = byte_count;
    msg_block[i] = sha_pkg::PadByte;
    i++;
    if (i > sha_pkg::LenPos) begin
      while (i < sha_pkg::BlkBytes) begin msg_block[i] = 8'h00; i++; end
      compress_block();
      i = 0;
    end
    while (i < sha_pkg::LenPos) begin msg_block[i] = 8'h00; i++; end
    for (int k = 0; k < 8; k++) msg_block[63-k] = bit_count[8*k +: 8];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hash_state[k];
      o.word_index  = 3'(k);
      o.last_word   = (k == 7);
      digest_queue.push_back(o);
    end
    digests_sent++;
    reload_hash();
  endfunction

  function automatic void add_msg(int len, bit fixed_byte, logic [7:0] val);
    sha_pkg::in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.mode = ModeAbsorb;
      it.data_byte = fixed_byte ? val : 8'($urandom);
      send_queue.push_back(it);
    end
    it.mode = ModeFinalize;
    it.data_byte = 8'($urandom);
    send_queue.push_back(it);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Driver: present items from the queue, with random sender gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) predict_item(in_if.data);
      if (send_queue.size() > 0 && !hold_off &&
          $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= send_queue.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each digest word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        words_seen++;
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, out_if.data);
          errors++;
        end else if (out_if.data !== digest_queue[0]) begin
          $display("%0t: mismatch, expected word %h idx %0d last %b, %s %h idx %0d last %b",
                   $time, digest_queue[0].digest_word, digest_queue[0].word_index,
                   digest_queue[0].last_word, "actual", out_if.data.digest_word,
                   out_if.data.word_index, out_if.data.last_word);
          errors++;
          void'(digest_queue.pop_front());
        end else begin
          void'(digest_queue.pop_front());
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (send_queue.size() > 0 || in_if.valid || digest_queue.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int len;
    errors = 0; words_seen = 0; digests_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    in_if.valid = 1'b0; in_if.data = '0; out_if.ready = 1'b0;
    reload_hash();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, extremes of bytes, short lengths
    add_msg(0, 1'b1, 8'h00);
    add_msg(1, 1'b1, 8'h00);
    add_msg(1, 1'b1, 8'hff);
    add_msg(3, 1'b1, 8'h61);
    add_msg(5, 1'b1, 8'haa);
    add_msg(4, 1'b1, 8'h55);
    add_msg(1, 1'b1, 8'h01);
    wait_drained();

    // Hold the sender until the pipeline is empty, then check block edges
    hold_off = 1'b1;
    repeat (250) @(posedge clk_i);
    hold_off = 1'b0;
    add_msg(56, 1'b0, 8'h00);
    add_msg(64, 1'b0, 8'h00);
    wait_drained();

    // Random messages over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 31) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 53 : 31) : 0;
      for (int m = 0; m < 3; m++) begin
        len = $urandom_range(10);
        add_msg(len, 1'b0, 8'h00);
      end
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    $display("Checked %0d digests (%0d words): empty, short, two-block pad and %s",
             digests_sent, words_seen, "full-block messages under sender and receiver gaps.");
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d words outstanding", digest_queue.size());
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
